[rtl/slope_peak_detector_unit_assert.svh]
// Assertion helpers shared by the RTL.
`ifndef SLOPE_PEAK_DETECTOR_UNIT_ASSERT_SVH
`define SLOPE_PEAK_DETECTOR_UNIT_ASSERT_SVH

// Checked only out of reset.
`define SPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/spd_pkg.sv]
`timescale 1ns / 1ps

package spd_pkg;

    localparam int MAX_BINS = 1024;
    localparam int MAX_HALF = 15;
    localparam int DEPTH    = 2 * MAX_HALF + 1;

    localparam int VAL_W  = 16;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 12;
    localparam int HALF_W = 4;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int PADDR_W     = 3;

    localparam logic [PADDR_W-1:0] ADDR_HALF_WINDOW = 3'd0;
    localparam logic [HALF_W-1:0]  HALF_RESET       = 4'd1;

    localparam logic [1:0] SLOPE_FLAT = 2'd0;
    localparam logic [1:0] SLOPE_DOWN = 2'd1;
    localparam logic [1:0] SLOPE_UP   = 2'd2;

    typedef struct packed {
        logic                    hit;
        logic [POS_W-1:0]        pos;
        logic signed [LEN_W-1:0] rise_len;
        logic signed [LEN_W-1:0] fall_len;
        logic [VAL_W-1:0]        value;
    } spd_peak_t;

endpackage

[rtl/spd_cfg.sv]
`timescale 1ns / 1ps

module spd_cfg
    import spd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [HALF_W-1:0]  half_window
);

    logic [HALF_W-1:0] half_window_reg;
    logic [HALF_W-1:0] half_window_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr == ADDR_HALF_WINDOW);

    always_comb
    begin
        half_window_next = half_window_reg;
        if (wr_en)
        begin
            half_window_next = pwdata[HALF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_window_reg <= HALF_RESET;
        end
        else
        begin
            half_window_reg <= half_window_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_HALF_WINDOW)
        begin
            prdata = {{(32 - HALF_W){1'b0}}, half_window_reg};
        end
    end

    assign half_window = half_window_reg;

endmodule

[rtl/spd_core.sv]
`timescale 1ns / 1ps

module spd_core
    import spd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [VAL_W-1:0]  bin_value,
    input  logic              last_bin,
    input  logic [HALF_W-1:0] half_window,
    output spd_peak_t         peak
);

    `include "slope_peak_detector_unit_assert.svh"

    logic [VAL_W-1:0]  delay_reg [DEPTH];
    logic [VAL_W-1:0]  shifted   [DEPTH];

    logic [POS_W-1:0]  bin_index_reg, bin_index_next;
    logic [1:0]        prev_slope_reg, prev_slope_next;
    logic [POS_W-1:0]  rise_start_reg, rise_start_next;
    logic [POS_W-1:0]  rise_end_reg, rise_end_next;
    logic [VAL_W-1:0]  rise_end_value_reg, rise_end_value_next;
    logic [POS_W-1:0]  fall_start_reg, fall_start_next;
    logic [VAL_W-1:0]  fall_start_value_reg, fall_start_value_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic [IDX_W-1:0]  h_eff;
    logic [VAL_W-1:0]  oldest;
    logic [1:0]        slope_cur;
    logic              warm;
    logic [POS_W-1:0]  centre;
    logic [POS_W-1:0]  before_pos;

    always_comb
    begin
        shifted[0] = bin_value;
        for (int k = 1; k < DEPTH; k++)
        begin
            shifted[k] = delay_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                delay_reg[k] <= shifted[k];
            end
        end
    end

    always_comb
    begin
        h_eff = (half_window > HALF_W'(MAX_HALF)) ? IDX_W'(MAX_HALF) : IDX_W'(half_window);
        fill_next  = (fill_reg < FILL_W'(DEPTH)) ? fill_reg + 1'b1 : fill_reg;
        warm       = fill_next >= (FILL_W'(h_eff) << 1) + 1'b1;
        oldest     = shifted[IDX_W'(h_eff << 1)];
        centre     = bin_index_reg - POS_W'(h_eff);
        before_pos = centre - 1'b1;

        if (bin_value > oldest)
        begin
            slope_cur = SLOPE_UP;
        end
        else if (bin_value < oldest)
        begin
            slope_cur = SLOPE_DOWN;
        end
        else
        begin
            slope_cur = SLOPE_FLAT;
        end

        prev_slope_next       = prev_slope_reg;
        rise_start_next       = rise_start_reg;
        rise_end_next         = rise_end_reg;
        rise_end_value_next   = rise_end_value_reg;
        fall_start_next       = fall_start_reg;
        fall_start_value_next = fall_start_value_reg;
        bin_index_next        = bin_index_reg + 1'b1;

        peak.hit      = warm && (prev_slope_reg == SLOPE_DOWN)
                        && ((slope_cur == SLOPE_UP) || (slope_cur == SLOPE_FLAT));
        peak.rise_len = {2'b00, rise_end_reg} - {2'b00, rise_start_reg} + 1'b1;
        peak.fall_len = {2'b00, before_pos} - {2'b00, fall_start_reg} + 1'b1;
        if (rise_end_value_reg < fall_start_value_reg)
        begin
            peak.pos   = fall_start_reg;
            peak.value = fall_start_value_reg;
        end
        else
        begin
            peak.pos   = rise_end_reg;
            peak.value = rise_end_value_reg;
        end

        if (warm)
        begin
            if (prev_slope_reg == SLOPE_FLAT && slope_cur == SLOPE_UP)
            begin
                rise_start_next = centre;
            end
            else if (prev_slope_reg == SLOPE_UP && slope_cur == SLOPE_DOWN)
            begin
                rise_end_next         = before_pos;
                rise_end_value_next   = shifted[IDX_W'(h_eff + 1'b1)];
                fall_start_next       = centre;
                fall_start_value_next = shifted[h_eff];
            end
            prev_slope_next = slope_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_index_reg        <= '0;
            prev_slope_reg       <= SLOPE_FLAT;
            rise_start_reg       <= '0;
            rise_end_reg         <= '0;
            rise_end_value_reg   <= '0;
            fall_start_reg       <= '0;
            fall_start_value_reg <= '0;
            fill_reg             <= '0;
        end
        else if (en)
        begin
            if (last_bin)
            begin
                bin_index_reg        <= '0;
                prev_slope_reg       <= SLOPE_FLAT;
                rise_start_reg       <= '0;
                rise_end_reg         <= '0;
                rise_end_value_reg   <= '0;
                fall_start_reg       <= '0;
                fall_start_value_reg <= '0;
                fill_reg             <= '0;
            end
            else
            begin
                bin_index_reg        <= bin_index_next;
                prev_slope_reg       <= prev_slope_next;
                rise_start_reg       <= rise_start_next;
                rise_end_reg         <= rise_end_next;
                rise_end_value_reg   <= rise_end_value_next;
                fall_start_reg       <= fall_start_next;
                fall_start_value_reg <= fall_start_value_next;
                fill_reg             <= fill_next;
            end
        end
    end

    `SPD_ASSERT(a_peak_after_down, peak.hit |-> (prev_slope_reg == SLOPE_DOWN), "peak without down-hill")
    `SPD_ASSERT(a_last_clears, (en && last_bin) |=> (fill_reg == '0 && bin_index_reg == '0), "last bin did not clear state")
    `SPD_ASSERT(a_slope_needs_warmup, (fill_reg == '0) |-> (prev_slope_reg == SLOPE_FLAT), "slope state set before warm-up")

endmodule

[rtl/slope_peak_detector_unit.sv]
`timescale 1ns / 1ps
// Slope-sign peak detector for a streamed 1D histogram.
// Input stream: one bin per transaction, tdata = bin_value, tlast marks the
// final bin of a histogram; all run state clears after that bin.
// Output stream: one transaction per detected peak, tdata carries position,
// rise length, fall length and peak value.
// APB port: one register, half_window at address 0 (reset value 1).
// Throughput: one bin per cycle unless a peak waits on a stalled output.
// A bin is held in the input register and processed as it moves on;
// m_axis_tvalid for a peak is registered as the bin that closes it moves on.
// The output register lets one more bin be taken while a peak waits.
// A stall on the output only holds the input register when a peak is
// pending, so a stalled receiver backs up into s_axis_tready.
// Reset clears the run state, both stream registers and sets half_window
// to 1; no peak is reported before 2*half_window+1 bins of a histogram.
module slope_peak_detector_unit
    import spd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] bin_value
    input  logic                   s_axis_tlast,   // last_bin
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [9:0] peak_pos, [21:10] rise_len,
                                                   // [33:22] fall_len, [49:34] peak_value
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    `include "slope_peak_detector_unit_assert.svh"

    logic              in_valid_reg;
    logic [VAL_W-1:0]  in_value_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    spd_peak_t         out_peak_reg;
    logic              advance;
    logic [HALF_W-1:0] half_window;
    spd_peak_t         peak;

    spd_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .half_window (half_window)
    );

    spd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .bin_value   (in_value_reg),
        .last_bin    (in_last_reg),
        .half_window (half_window),
        .peak        (peak)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= peak.hit;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_value_reg <= s_axis_tdata[VAL_W-1:0];
            in_last_reg  <= s_axis_tlast;
        end
        if (advance && peak.hit)
        begin
            out_peak_reg <= peak;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {
        {(OUT_TDATA_W - POS_W - 2 * LEN_W - VAL_W){1'b0}},
        out_peak_reg.value,
        out_peak_reg.fall_len,
        out_peak_reg.rise_len,
        out_peak_reg.pos
    };

    `SPD_ASSERT(a_stall_holds_pipe, (out_valid_reg && !m_axis_tready) |-> !advance, "advanced into a stalled output")
    `SPD_ASSERT(a_empty_accepts, !in_valid_reg |-> s_axis_tready, "empty input register not ready")
    `SPD_ASSERT(a_result_from_hit, ($rose(m_axis_tvalid)) |-> $past(advance), "output valid without processed bin")
    `SPD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!m_axis_tvalid && !in_valid_reg), "stream registers not cleared in reset")

endmodule

[tb/sv/tb_slope_peak_detector_unit.sv]
`timescale 1ns / 1ps

module tb_slope_peak_detector_unit;
    import spd_pkg::*;

    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_NONE,
        ROW_PEAK,
        ROW_CFG
    } row_kind_t;

    typedef enum int {
        STYLE_HILLS,
        STYLE_FINE_NOISE,
        STYLE_WIDE_NOISE,
        STYLE_RAILS
    } bin_style_t;

    typedef struct {
        row_kind_t         kind;
        logic [VAL_W-1:0]  data;
        logic              last;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  rise;
        logic [LEN_W-1:0]  fall;
        logic [VAL_W-1:0]  pval;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam int PHASES   = 10;
    localparam int HALF_PLAN [PHASES] = '{15, 0, 1, 2, 3, 7, 15, 1, 4, 5};

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] bin_value
    logic                   s_axis_tlast;   // last_bin
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [9:0] peak_pos, [21:10] rise_len,
                                            // [33:22] fall_len, [49:34] peak_value
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    slope_peak_detector_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the detector state
    logic [VAL_W-1:0]  win_bins [DEPTH];
    logic [POS_W-1:0]  next_bin_pos;
    logic [1:0]        last_trend;
    logic [POS_W-1:0]  rise_from;
    logic [POS_W-1:0]  rise_to;
    logic [VAL_W-1:0]  rise_to_val;
    logic [POS_W-1:0]  fall_from;
    logic [VAL_W-1:0]  fall_from_val;
    int                bins_seen;
    logic [HALF_W-1:0] half_cfg;

    spd_peak_t pending_peaks [$];
    int        fail_count;
    bit        calm;

    // directed: warm-up, clean hill, full-scale tie, peak with no up-hill, zero window
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_NONE, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_NONE, 16'd4,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd8,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd6,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd2,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PEAK, 16'd2,     1'b1, 10'd2, 12'd2, 12'd2, 16'd8},
        '{ROW_NONE, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_NONE, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd65535, 1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd65535, 1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PEAK, 16'd0,     1'b1, 10'd2, 12'd2, 12'd2, 16'd65535},
        '{ROW_NONE, 16'd9,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_NONE, 16'd9,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PRED, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_PEAK, 16'd0,     1'b1, 10'd0, 12'd1, 12'd3, 16'd0},
        '{ROW_CFG,  16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_NONE, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_NONE, 16'd65535, 1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_NONE, 16'd0,     1'b0, 10'd0, 12'd0, 12'd0, 16'd0},
        '{ROW_NONE, 16'd65535, 1'b1, 10'd0, 12'd0, 12'd0, 16'd0}
    };

    function automatic void clear_run();
        int k;
        for (k = 0; k < DEPTH; k++)
            win_bins[k] = '0;
        next_bin_pos  = '0;
        last_trend    = SLOPE_FLAT;
        rise_from     = '0;
        rise_to       = '0;
        rise_to_val   = '0;
        fall_from     = '0;
        fall_from_val = '0;
        bins_seen     = 0;
    endfunction

    function automatic logic [LEN_W-1:0] span_len(input logic [POS_W-1:0] hi,
                                                  input logic [POS_W-1:0] lo);
        logic [LEN_W-1:0] d;
        d = {2'b00, hi} - {2'b00, lo} + 12'd1;
        return d;
    endfunction

    function automatic bit predict_peak(input logic [VAL_W-1:0] v, input logic l,
                                        output spd_peak_t pk);
        int               k;
        int               h;
        logic [1:0]       trend;
        logic [POS_W-1:0] centre;
        logic [POS_W-1:0] prior_pos;
        bit               hit;
        hit = 0;
        pk  = '0;
        h   = (int'(half_cfg) > MAX_HALF) ? MAX_HALF : int'(half_cfg);
        for (k = DEPTH - 1; k > 0; k--)
            win_bins[k] = win_bins[k-1];
        win_bins[0] = v;
        if (bins_seen < DEPTH)
            bins_seen++;
        if (bins_seen >= 2 * h + 1)
        begin
            if (win_bins[0] > win_bins[2*h])
                trend = SLOPE_UP;
            else if (win_bins[0] < win_bins[2*h])
                trend = SLOPE_DOWN;
            else
                trend = SLOPE_FLAT;
            centre    = next_bin_pos - POS_W'(h);
            prior_pos = next_bin_pos - POS_W'(h) - 10'd1;
            if (last_trend == SLOPE_FLAT && trend == SLOPE_UP)
            begin
                rise_from = centre;
            end
            else if (last_trend == SLOPE_UP && trend == SLOPE_DOWN)
            begin
                rise_to       = prior_pos;
                rise_to_val   = win_bins[h+1];
                fall_from     = centre;
                fall_from_val = win_bins[h];
            end
            if (last_trend == SLOPE_DOWN && (trend == SLOPE_UP || trend == SLOPE_FLAT))
            begin
                pk.hit   = 1'b1;
                pk.pos   = rise_to;
                pk.value = rise_to_val;
                if (rise_to_val < fall_from_val)
                begin
                    pk.pos   = fall_from;
                    pk.value = fall_from_val;
                end
                pk.rise_len = span_len(rise_to, rise_from);
                pk.fall_len = span_len(prior_pos, fall_from);
                hit = 1;
            end
            last_trend = trend;
        end
        next_bin_pos = next_bin_pos + 10'd1;
        if (l)
            clear_run();
        return hit;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    // one bin transaction; called and returns at a falling edge
    task automatic send_bin(input logic [VAL_W-1:0] v, input logic l, input row_kind_t kind,
                            input spd_peak_t typed);
        int        gap;
        spd_peak_t guess;
        bit        hit;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hit = predict_peak(v, l, guess);
        if (kind == ROW_PEAK)
            pending_peaks = {pending_peaks, typed};
        else if (kind == ROW_PRED && hit)
            pending_peaks = {pending_peaks, guess};
        @(negedge clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_peaks.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_HALF_WINDOW;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_half(input logic [HALF_W-1:0] hv);
        logic [31:0] rd;
        apb_xfer(1'b1, {28'd0, hv}, rd);
        half_cfg = hv;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== {28'd0, hv})
        begin
            $display("%0t: half_window readback mismatch, expected 0x%0h, actual 0x%0h",
                     $time, hv, rd);
            fail_count++;
        end
    endtask

    task automatic send_histogram(input int len, input bit with_last);
        bin_style_t       style;
        int               pick;
        int               level;
        int               dir;
        int               step_max;
        int               n;
        logic [VAL_W-1:0] v;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            style = STYLE_HILLS;
        else if (pick < 15)
            style = STYLE_FINE_NOISE;
        else if (pick < 18)
            style = STYLE_WIDE_NOISE;
        else
            style = STYLE_RAILS;
        level = $urandom_range(0, 65535);
        dir   = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 2))
            0: step_max = 3;
            1: step_max = 64;
            default: step_max = 8192;
        endcase
        for (n = 0; n < len; n++)
        begin
            case (style)
                STYLE_HILLS:
                begin
                    if ($urandom_range(0, 7) == 0)
                        dir = -dir;
                    if ($urandom_range(0, 3) != 0)
                        level = level + dir * int'($urandom_range(1, step_max));
                    if (level < 0)
                    begin
                        level = 0;
                        dir   = 1;
                    end
                    if (level > 65535)
                    begin
                        level = 65535;
                        dir   = -1;
                    end
                    v = level[15:0];
                end
                STYLE_FINE_NOISE: v = 16'($urandom_range(0, 2));
                STYLE_WIDE_NOISE: v = 16'($urandom_range(0, 65535));
                default: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            send_bin(v, with_last && (n == len - 1), ROW_PRED, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side
    initial
    begin
        int          stall;
        spd_peak_t   want;
        logic [55:0] beat;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            beat = m_axis_tdata;
            if (pending_peaks.size() == 0)
            begin
                $display("%0t: unexpected peak, expected none, actual 0x%0h", $time, beat);
                fail_count++;
            end
            else
            begin
                want = pending_peaks.pop_front();
                check_field("peak_pos", 16'(want.pos), 16'(beat[9:0]));
                check_field("rise_len", {4'd0, want.rise_len}, {4'd0, beat[21:10]});
                check_field("fall_len", {4'd0, want.fall_len}, {4'd0, beat[33:22]});
                check_field("peak_value", want.value, beat[49:34]);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        int        i;
        int        p;
        int        sent;
        int        len;
        dir_row_t  row;
        spd_peak_t typed;
        fail_count    = 0;
        calm          = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        clear_run();
        half_cfg = HALF_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                set_half(row.data[HALF_W-1:0]);
            end
            else
            begin
                typed          = '0;
                typed.hit      = 1'b1;
                typed.pos      = row.pos;
                typed.rise_len = row.rise;
                typed.fall_len = row.fall;
                typed.value    = row.pval;
                send_bin(row.data, row.last, row.kind, typed);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            set_half(HALF_W'(HALF_PLAN[p]));
            calm = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 70)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 45);
                send_histogram(len, 1'b1);
                sent += len;
            end
            // leave a histogram open across the next register change
            if ($urandom_range(0, 1))
                send_histogram($urandom_range(3, 20), 1'b0);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_peaks.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
